### hw/rtl/spm_pkg.sv
`default_nettype none

package spm_pkg;

    // Window cells hold the bytes before the arriving one.
    localparam int WIN_DEPTH = 16;
    localparam int PAT_COUNT = 12;
    localparam int PAT_SPAN  = WIN_DEPTH + 1;

    typedef logic [PAT_SPAN-1:0][7:0] pat_text_t;
    typedef logic [PAT_COUNT-1:0]     pat_vec_t;

    // Literals are right aligned and zero padded.
    // Byte [d] is the pattern byte d places before its last byte; zero means no byte there.
    localparam pat_text_t PAT_TEXT [PAT_COUNT] = '{
        pat_text_t'("/.ssh/"),
        pat_text_t'("/.gnupg/"),
        pat_text_t'("/.aws/"),
        pat_text_t'({"/.moz", "illa/"}),
        pat_text_t'({"/goo", "gle-chrome/"}),
        pat_text_t'("/Documents/"),
        pat_text_t'("/Downloads/"),
        pat_text_t'("/.password-store/"),
        pat_text_t'("/etc/passwd"),
        pat_text_t'("/etc/shadow"),
        pat_text_t'("/etc/sudoers"),
        pat_text_t'("/etc/ssh/")
    };

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/spm_cell.sv
`default_nettype none

// One window cell: holds a byte, passes it on, and checks it against
// every pattern at its fixed distance from the arriving byte.
module spm_cell #(
    parameter int POS = 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire spm_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]          byte_in,
    output logic [7:0]               byte_out,
    output spm_pkg::pat_vec_t        hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            byte_reg <= 8'h00;
        end else if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // A pattern shorter than this distance does not care about this cell.
    always_comb begin
        logic [7:0] pat_b;
        pat_b = 8'h00;
        for (int p = 0; p < spm_pkg::PAT_COUNT; p++) begin
            pat_b  = spm_pkg::PAT_TEXT[p][POS];
            hit[p] = (pat_b == 8'h00) || (pat_b == byte_reg);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sensitive_path_matcher.sv
`default_nettype none

// Channel | ports                                  | role
// --------+----------------------------------------+-------------------------------
// input   | s_valid s_ready s_path_byte s_last_byte | one path byte per beat
// result  | m_valid m_ready m_sensitive            | one beat per path, on last byte
//
// Input beats can be taken back to back; the compare of the window cells and
// the arriving byte is a single level of constant compares and a 17-input AND.
// A result appears in the cycle after the last byte is taken.
// s_ready stays high while the result register is empty or being drained,
// so input beats stall only while a finished result waits unread.
// Reset (aresetn low, synchronous) empties the window, flags, count and result.
module sensitive_path_matcher #(
    parameter int MAX_PATH_BYTES = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_path_byte,
    input  wire logic       s_last_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_sensitive
);

    localparam int CNT_W = $clog2(MAX_PATH_BYTES);

    // scan state
    logic             found_reg, found_next;
    logic             ended_reg, ended_next;
    logic [CNT_W-1:0] count_reg, count_next;
    // result register
    logic             m_valid_reg, m_valid_next;
    logic             m_sens_reg, m_sens_next;

    logic                accept;
    logic                scan;
    logic                take_byte;
    logic                any_hit;
    spm_pkg::cell_ctrl_t cell_ctrl;

    logic [7:0]        win_byte [spm_pkg::WIN_DEPTH];
    spm_pkg::pat_vec_t cell_hit [spm_pkg::WIN_DEPTH];
    spm_pkg::pat_vec_t cur_hit;
    spm_pkg::pat_vec_t all_hit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Bytes past a NUL or past the length limit are dropped.
    assign scan      = !ended_reg && (count_reg < CNT_W'(MAX_PATH_BYTES - 1));
    assign take_byte = accept && scan && (s_path_byte != 8'h00);

    assign cell_ctrl.shift = take_byte;
    assign cell_ctrl.clear = accept && s_last_byte;

    // Window chain: cell 0 holds the byte just before the arriving one.
    for (genvar k = 0; k < spm_pkg::WIN_DEPTH; k++) begin : g_cell
        logic [7:0] feed;
        if (k == 0) begin : g_head
            assign feed = s_path_byte;
        end else begin : g_link
            assign feed = win_byte[k-1];
        end
        spm_cell #(
            .POS (k + 1)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .byte_in  (feed),
            .byte_out (win_byte[k]),
            .hit      (cell_hit[k])
        );
    end

    // Last pattern byte is never zero, so the arriving byte always compares.
    always_comb begin
        for (int p = 0; p < spm_pkg::PAT_COUNT; p++) begin
            cur_hit[p] = (spm_pkg::PAT_TEXT[p][0] == s_path_byte);
        end
        all_hit = cur_hit;
        for (int k = 0; k < spm_pkg::WIN_DEPTH; k++) begin
            all_hit = all_hit & cell_hit[k];
        end
    end

    assign any_hit = |all_hit;

    always_comb begin
        found_next   = found_reg;
        ended_next   = ended_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_sens_next  = m_sens_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept && scan) begin
            if (s_path_byte == 8'h00) begin
                ended_next = 1'b1;
            end else begin
                found_next = found_reg || any_hit;
                count_next = count_reg + CNT_W'(1);
            end
        end

        // Last byte: publish and start the next path clean.
        if (accept && s_last_byte) begin
            m_valid_next = 1'b1;
            m_sens_next  = found_next;
            found_next   = 1'b0;
            ended_next   = 1'b0;
            count_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg   <= 1'b0;
            ended_reg   <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            found_reg   <= found_next;
            ended_reg   <= ended_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_sens_reg <= m_sens_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_sensitive = m_sens_reg;

endmodule

`default_nettype wire

### hw/rtl/spm_port_chk.sv
`default_nettype none

module spm_port_chk (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_path_byte,
    input wire logic       s_last_byte,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_sensitive
);

    // Held result beat keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sensitive))
        else $error("result beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Only a last byte produces a result beat.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_byte && !(m_valid && !m_ready) |=> !m_valid)
        else $error("result beat without a last byte");

    // Input stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with result register free");

    // Stalled input beat waits unchanged.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_path_byte) && $stable(s_last_byte))
        else $error("input beat dropped or changed while stalled");

endmodule

bind sensitive_path_matcher spm_port_chk u_spm_port_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_path_byte (s_path_byte),
    .s_last_byte (s_last_byte),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_sensitive (m_sensitive)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Predictor constants, kept apart from the RTL package on purpose.
    localparam int MAX_PATH_BYTES = 256;
    localparam int WIN_BYTES      = 16;
    localparam int PAT_NUM        = 12;
    localparam int RANDOM_BEATS   = 100;
    localparam int IDLE_MAX       = 19;

    typedef logic [7:0] byte_q_t[$];

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_path_byte;
    logic       s_last_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_sensitive;

    sensitive_path_matcher i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_path_byte (s_path_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sensitive (m_sensitive)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Two entries are completed at start of run (their literals are split).
    string sens_pat[PAT_NUM] = '{
        "/.ssh/", "/.gnupg/", "/.aws/", "/.moz", "/goo", "/Documents/",
        "/Downloads/", "/.password-store/", "/etc/passwd", "/etc/shadow",
        "/etc/sudoers", "/etc/ssh/"
    };
    string name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._-";

    // Predictor state: scan window (entry 0 = newest byte), flags, scan count.
    logic [7:0] win_bytes [WIN_BYTES];
    logic       hit_seen;
    logic       nul_seen;
    int         scan_count;

    // Expected m_sensitive per finished path, oldest first.
    logic       sens_expected[$];

    // Traffic knobs; rx_max and rx_hold are shared with the receiver process.
    int tx_max;
    int rx_max;
    int rx_hold;

    int err_cnt;
    int beats_sent;
    int paths_sent;
    int results_seen;
    int flagged_seen;
    logic want_sens;

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic void clear_scan();
        foreach (win_bytes[i]) win_bytes[i] = 8'h00;
        hit_seen   = 1'b0;
        nul_seen   = 1'b0;
        scan_count = 0;
    endfunction

    // True when pattern p ends exactly at the arriving byte cur.
    function automatic logic pattern_ends_here(input string p, input logic [7:0] cur);
        int n;
        n = p.len();
        if (8'(p[n-1]) != cur) return 1'b0;
        for (int k = 1; k < n; k++) begin
            if (8'(p[n-1-k]) != win_bytes[k-1]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the predictor by one accepted beat; queue a result on last byte.
    function automatic void scan_byte(input logic [7:0] b, input logic lst);
        if (!nul_seen && scan_count < MAX_PATH_BYTES - 1) begin
            if (b == 8'h00) begin
                nul_seen = 1'b1;
            end else begin
                foreach (sens_pat[i]) begin
                    if (pattern_ends_here(sens_pat[i], b)) hit_seen = 1'b1;
                end
                for (int k = WIN_BYTES - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
                win_bytes[0] = b;
                scan_count++;
            end
        end
        if (lst) begin
            sens_expected.push_back(hit_seen);
            clear_scan();
        end
    endfunction

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(8'(s[i]));
        return q;
    endfunction

    function automatic byte_q_t filler(input int n);
        byte_q_t q;
        repeat (n) q.push_back(8'(name_chars[$urandom_range(0, name_chars.len() - 1)]));
        return q;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    // Valid stays high between back-to-back beats, only the payload moves.
    task automatic send_beat(input logic [7:0] b, input logic lst);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_path_byte = b;
        s_last_byte = lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_byte(b, lst);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_path(input byte_q_t pb);
        foreach (pb[i]) send_beat(pb[i], i == pb.size() - 1);
        paths_sent++;
    endtask

    // Sender stops and waits for every outstanding result.
    task automatic drain();
        s_valid = 1'b0;
        while (sens_expected.size() != 0) @(negedge aclk);
    endtask

    // One random path: mostly real-looking components and patterns, plus
    // truncated patterns, corrupted patterns, raw bytes and stray zeros.
    function automatic byte_q_t random_path();
        byte_q_t pb;
        string   s;
        int      pieces;
        int      n;
        int      idx;
        pieces = $urandom_range(1, 6);
        for (int i = 0; i < pieces; i++) begin
            s = sens_pat[$urandom_range(0, PAT_NUM - 1)];
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    pb = {pb, text_bytes(s)};
                end
                3: begin
                    pb = {pb, text_bytes(s.substr(0, $urandom_range(0, s.len() - 2)))};
                end
                4: begin
                    n   = pb.size();
                    pb  = {pb, text_bytes(s)};
                    idx = n + $urandom_range(0, s.len() - 1);
                    pb[idx] ^= 8'($urandom_range(1, 255));
                end
                5, 6, 7: begin
                    pb.push_back("/");
                    pb = {pb, filler($urandom_range(1, 8))};
                end
                8: begin
                    repeat ($urandom_range(1, 4)) pb.push_back(8'($urandom_range(1, 255)));
                end
                default: begin
                    pb.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        return pb;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Every pattern as a whole path.
    task automatic test_each_pattern();
        tx_max = 0;
        rx_max = 0;
        foreach (sens_pat[i]) send_path(text_bytes(sens_pat[i]));
        drain();
    endtask

    task automatic test_special_cases();
        byte_q_t pb;
        tx_max = 2;
        rx_max = 2;
        // empty path: only the terminating zero
        send_path('{8'h00});
        // one-byte paths at the byte extremes
        send_path('{8'h01});
        send_path('{8'hFF});
        send_path('{8'h80});
        // pattern after the zero byte is ignored
        pb = {text_bytes("ab"), 8'h00, text_bytes("/.ssh/")};
        send_path(pb);
        // zero byte as the last beat, after a full pattern
        pb = {text_bytes("/etc/shadow"), 8'h00};
        send_path(pb);
        // near misses: missing last byte, wrong case, shared prefix
        send_path(text_bytes("/etc/passw"));
        send_path(text_bytes("/.SSH/"));
        send_path(text_bytes("/etc/s/h"));
        // a pattern split over two paths must not match (state cleared)
        send_path(text_bytes("x/.s"));
        send_path(text_bytes("sh/"));
        drain();
    endtask

    // Scan stops after MAX_PATH_BYTES-1 bytes.
    task automatic test_length_limit();
        tx_max = 0;
        rx_max = 3;
        // pattern ends on the last byte still scanned
        send_path({filler(MAX_PATH_BYTES - 7), text_bytes("/.ssh/")});
        // one byte too far
        send_path({filler(MAX_PATH_BYTES - 6), text_bytes("/.ssh/")});
        // short path right after a saturated one
        send_path(text_bytes("/etc/ssh/"));
        drain();
    endtask

    // Receiver holds off while the sender streams short paths back to back,
    // so the result register stays full and s_ready drops.
    task automatic test_backpressure();
        tx_max  = 0;
        rx_max  = 0;
        rx_hold = 80;
        for (int i = 0; i < 12; i++) begin
            if ((i % 2) != 0) begin
                send_path({text_bytes("/.gnupg/"), 8'($urandom_range(1, 255))});
            end else begin
                send_path({text_bytes("ab"), 8'($urandom_range(1, 255))});
            end
        end
        drain();
    endtask

    task automatic test_random_paths();
        byte_q_t pb;
        int      first_beat;
        first_beat = beats_sent;
        while (beats_sent - first_beat < RANDOM_BEATS) begin
            // change idle mode every few paths; some stretches have no gaps at all
            if (paths_sent % 12 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin tx_max = 0;        rx_max = 0;        end
                    1: begin tx_max = IDLE_MAX; rx_max = IDLE_MAX; end
                    2: begin tx_max = IDLE_MAX; rx_max = 0;        end
                    default: begin tx_max = 0;  rx_max = IDLE_MAX; end
                endcase
            end
            pb = random_path();
            send_path(pb);
        end
        drain();
    endtask

    // ---------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------

    // Receiver: per result a random stall, or a long hold when a test asks.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold > 0) begin
                m_ready = 1'b0;
                repeat (rx_hold) @(negedge aclk);
                rx_hold = 0;
            end else begin
                int stall;
                stall = $urandom_range(0, rx_max);
                if (stall > 0) begin
                    m_ready = 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid && rx_hold == 0);
            @(negedge aclk);
        end
    end

    // Result checker: every taken beat against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sens_expected.size() == 0) begin
                report_mismatch("result beat with no path pending");
            end else begin
                want_sens = sens_expected.pop_front();
                results_seen++;
                if (m_sensitive !== want_sens) begin
                    report_mismatch($sformatf("sensitive=%b, predicted %b",
                                              m_sensitive, want_sens));
                end
                if (m_sensitive === 1'b1) flagged_seen++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_path_byte = 8'h00;
        s_last_byte = 1'b0;
        tx_max      = 0;
        rx_max      = 0;
        rx_hold     = 0;
        sens_pat[3] = {sens_pat[3], "illa/"};
        sens_pat[4] = {sens_pat[4], "gle-chrome/"};
        clear_scan();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_each_pattern();
        test_special_cases();
        test_length_limit();
        test_backpressure();
        test_random_paths();

        drain();
        // result lands in the cycle after the last byte; allow some slack
        repeat (10) @(negedge aclk);
        if (sens_expected.size() != 0) report_mismatch("paths left without a result");

        $display("run covered %0d paths in %0d beats: every pattern, empty and truncated",
                 paths_sent, beats_sent);
        $display("paths, long stalls and random traffic; %0d results, %0d flagged",
                 results_seen, flagged_seen);
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("watchdog expired, %0d results still pending", sens_expected.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
